@@ rtl/mwo_pkg.sv @@
`timescale 1ns / 1ps

package mwo_pkg;

  // Field and register widths
  localparam int TICK_W = 32;
  localparam int SEC_W  = 32;
  localparam int NSEC_W = 30;
  localparam int VEL_W  = 32;
  localparam int STAT_W = 2;

  localparam int TPR_W  = 16;
  localparam int GEAR_W = 8;
  localparam int RAD_W  = 20;
  localparam int HTS_W  = 24;
  localparam int SKIP_W = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TPR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GEAR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HTS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP = 3'd4;

  // Register reset values
  localparam logic [TPR_W-1:0]  TPR_RST  = 16'd41;
  localparam logic [GEAR_W-1:0] GEAR_RST = 8'd5;
  localparam logic [RAD_W-1:0]  RAD_RST  = 20'd75000;
  localparam logic [HTS_W-1:0]  HTS_RST  = 24'd360000;
  localparam logic [SKIP_W-1:0] SKIP_RST = 8'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_INIT = 2'd0;
  localparam logic [STAT_W-1:0] STAT_CALC = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ZERO = 2'd2;
  localparam logic [STAT_W-1:0] STAT_SAT  = 2'd3;

  localparam int FRAC_BITS_DEF = 16;

  // Arithmetic constants: pi in Q29, ns per second, linear and yaw scale
  localparam logic [30:0] PI_Q29     = 31'd1686629713;
  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
  localparam logic [9:0]  K_LIN      = 10'd1000;
  localparam logic [29:0] K_YAW      = 30'd1000000000;

  // Internal widths
  localparam int DIFF_W = 33;   // one wheel delta, seconds delta
  localparam int NSD_W  = 31;   // nanoseconds delta
  localparam int SUM_W  = 35;   // signed wheel combination
  localparam int DT_W   = 64;   // signed interval in ns
  localparam int DMAG_W = 63;   // interval magnitude
  localparam int P_W    = 51;   // radius * pi
  localparam int PK_W   = 81;   // radius * pi * scale
  localparam int DV_W   = 87;   // |dt| * ticks * gear
  localparam int DY_W   = 111;  // |dt| * ticks * gear * track
  localparam int MB_W   = 35;   // multiplier operand
  localparam int Q_W    = 33;   // quotient, top bit flags overflow
  localparam int DIV_STEPS = 33;
  localparam int CNT_W  = 6;
  localparam int AXIS_W = 2;
  localparam int N_AXES = 3;

  localparam logic [AXIS_W-1:0] AXIS_YAW = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_DIFF,
    OP_DTMUL,
    OP_DTADD,
    OP_MAG,
    OP_MUL_LOAD,
    OP_MUL_STEP,
    OP_MUL_STORE,
    OP_X_LOAD,
    OP_X_ADD,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_RESULT,
    OP_EMIT
  } dp_op_t;

  // Products built by the shift-add multiplier
  typedef enum logic [2:0] {
    JOB_P,
    JOB_PKV,
    JOB_PKY,
    JOB_DN,
    JOB_DG,
    JOB_DL,
    JOB_NUM
  } mul_job_t;

  typedef struct packed {
    dp_op_t                  op;
    mul_job_t                job;
    logic [AXIS_W-1:0]       axis;
    logic [STAT_W-1:0]       code;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic dt_zero;
  } dp_stat_t;

endpackage

@@ rtl/mwo_ctrl.sv @@
`timescale 1ns / 1ps

module mwo_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  input  logic [mwo_pkg::SKIP_W-1:0]  skip_count,
  output mwo_pkg::dp_cmd_t            cmd,
  input  mwo_pkg::dp_stat_t           stat
);

  localparam int CNT_W  = mwo_pkg::CNT_W;
  localparam int SKIP_W = mwo_pkg::SKIP_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_DTMUL,
    S_DTADD,
    S_MAG,
    S_CHK,
    S_MLOAD,
    S_MSTEP,
    S_MSTORE,
    S_XLOAD,
    S_XADD,
    S_DLOAD,
    S_DSTEP,
    S_RES,
    S_EMIT
  } state_t;

  state_t                            state_r, state_nxt;
  logic                              started_r, started_nxt;
  logic [SKIP_W-1:0]                 skip_cnt_r, skip_cnt_nxt;
  mwo_pkg::mul_job_t                 job_r, job_nxt;
  logic [mwo_pkg::AXIS_W-1:0]        axis_r, axis_nxt;
  logic [CNT_W-1:0]                  cnt_r, cnt_nxt;
  logic [mwo_pkg::STAT_W-1:0]        code_r, code_nxt;
  logic                              out_valid_r, out_valid_nxt;

  assign out_valid = out_valid_r;

  // Next state and command decode
  always_comb begin
    state_nxt     = state_r;
    started_nxt   = started_r;
    skip_cnt_nxt  = skip_cnt_r;
    job_nxt       = job_r;
    axis_nxt      = axis_r;
    cnt_nxt       = cnt_r;
    code_nxt      = code_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd.op        = mwo_pkg::OP_NONE;
    cmd.job       = job_r;
    cmd.axis      = axis_r;
    cmd.code      = code_r;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = mwo_pkg::OP_CAPTURE;
          if (!started_r) begin
            code_nxt  = mwo_pkg::STAT_INIT;
            state_nxt = S_EMIT;
          end else if (skip_cnt_r < skip_count) begin
            skip_cnt_nxt = skip_cnt_r + 1'b1;
          end else begin
            state_nxt = S_DIFF;
          end
        end
      end
      S_DIFF: begin
        cmd.op    = mwo_pkg::OP_DIFF;
        state_nxt = S_DTMUL;
      end
      S_DTMUL: begin
        cmd.op    = mwo_pkg::OP_DTMUL;
        state_nxt = S_DTADD;
      end
      S_DTADD: begin
        cmd.op    = mwo_pkg::OP_DTADD;
        state_nxt = S_MAG;
      end
      S_MAG: begin
        cmd.op    = mwo_pkg::OP_MAG;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (stat.dt_zero) begin
          code_nxt  = mwo_pkg::STAT_ZERO;
          state_nxt = S_EMIT;
        end else begin
          code_nxt  = mwo_pkg::STAT_CALC;
          job_nxt   = mwo_pkg::JOB_P;
          axis_nxt  = '0;
          state_nxt = S_MLOAD;
        end
      end
      S_MLOAD: begin
        cmd.op    = mwo_pkg::OP_MUL_LOAD;
        state_nxt = S_MSTEP;
      end
      S_MSTEP: begin
        if (stat.mul_done) begin
          state_nxt = (job_r == mwo_pkg::JOB_NUM) ? S_XLOAD : S_MSTORE;
        end else begin
          cmd.op = mwo_pkg::OP_MUL_STEP;
        end
      end
      S_MSTORE: begin
        cmd.op    = mwo_pkg::OP_MUL_STORE;
        job_nxt   = mwo_pkg::mul_job_t'(job_r + 3'd1);
        state_nxt = S_MLOAD;
      end
      S_XLOAD: begin
        cmd.op    = mwo_pkg::OP_X_LOAD;
        state_nxt = S_XADD;
      end
      S_XADD: begin
        cmd.op    = mwo_pkg::OP_X_ADD;
        state_nxt = S_DLOAD;
      end
      S_DLOAD: begin
        cmd.op    = mwo_pkg::OP_DIV_LOAD;
        cnt_nxt   = '0;
        state_nxt = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.op = mwo_pkg::OP_DIV_STEP;
        if (cnt_r == CNT_W'(mwo_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_RES;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_RES: begin
        cmd.op = mwo_pkg::OP_RESULT;
        if (axis_r == mwo_pkg::AXIS_YAW) begin
          state_nxt = S_EMIT;
        end else begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = S_MLOAD;
        end
      end
      S_EMIT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.op        = mwo_pkg::OP_EMIT;
          out_valid_nxt = 1'b1;
          started_nxt   = 1'b1;
          if (code_r != mwo_pkg::STAT_INIT) begin
            skip_cnt_nxt = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      started_r   <= 1'b0;
      skip_cnt_r  <= '0;
      job_r       <= mwo_pkg::JOB_P;
      axis_r      <= '0;
      cnt_r       <= '0;
      code_r      <= mwo_pkg::STAT_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      started_r   <= started_nxt;
      skip_cnt_r  <= skip_cnt_nxt;
      job_r       <= job_nxt;
      axis_r      <= axis_nxt;
      cnt_r       <= cnt_nxt;
      code_r      <= code_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/mwo_dp.sv @@
`timescale 1ns / 1ps

module mwo_dp #(
  parameter int FRAC_BITS = mwo_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic [mwo_pkg::TPR_W-1:0]          ticks_per_rev,
  input  logic [mwo_pkg::GEAR_W-1:0]         gear_ratio,
  input  logic [mwo_pkg::RAD_W-1:0]          wheel_radius_um,
  input  logic [mwo_pkg::HTS_W-1:0]          half_track_sum_um,
  input  logic signed [mwo_pkg::TICK_W-1:0]  tick_front_left,
  input  logic signed [mwo_pkg::TICK_W-1:0]  tick_front_right,
  input  logic signed [mwo_pkg::TICK_W-1:0]  tick_rear_right,
  input  logic signed [mwo_pkg::TICK_W-1:0]  tick_rear_left,
  input  logic [mwo_pkg::SEC_W-1:0]          stamp_sec,
  input  logic [mwo_pkg::NSEC_W-1:0]         stamp_nsec,
  input  mwo_pkg::dp_cmd_t                   cmd,
  output mwo_pkg::dp_stat_t                  stat,
  output logic signed [mwo_pkg::VEL_W-1:0]   vel_x,
  output logic signed [mwo_pkg::VEL_W-1:0]   vel_y,
  output logic signed [mwo_pkg::VEL_W-1:0]   yaw_rate,
  output logic [mwo_pkg::SEC_W-1:0]          res_sec,
  output logic [mwo_pkg::NSEC_W-1:0]         res_nsec,
  output logic [mwo_pkg::STAT_W-1:0]         status
);

  // Shared register width: divisor shifted up by the quotient length
  localparam int DP_W   = 175 - FRAC_BITS;
  localparam int SH_X   = 30 - FRAC_BITS;
  localparam int SH_D   = 63 - FRAC_BITS;

  localparam int TICK_W = mwo_pkg::TICK_W;
  localparam int SEC_W  = mwo_pkg::SEC_W;
  localparam int NSEC_W = mwo_pkg::NSEC_W;
  localparam int VEL_W  = mwo_pkg::VEL_W;
  localparam int DIFF_W = mwo_pkg::DIFF_W;
  localparam int NSD_W  = mwo_pkg::NSD_W;
  localparam int SUM_W  = mwo_pkg::SUM_W;
  localparam int DT_W   = mwo_pkg::DT_W;
  localparam int DMAG_W = mwo_pkg::DMAG_W;
  localparam int P_W    = mwo_pkg::P_W;
  localparam int PK_W   = mwo_pkg::PK_W;
  localparam int DV_W   = mwo_pkg::DV_W;
  localparam int DY_W   = mwo_pkg::DY_W;
  localparam int MB_W   = mwo_pkg::MB_W;
  localparam int Q_W    = mwo_pkg::Q_W;
  localparam int N_AX   = mwo_pkg::N_AXES;

  localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

  // Sample and reference
  logic signed [TICK_W-1:0] cur_tick_r  [4];
  logic signed [TICK_W-1:0] prev_tick_r [4];
  logic [SEC_W-1:0]         cur_sec_r, prev_sec_r;
  logic [NSEC_W-1:0]        cur_nsec_r, prev_nsec_r;

  // Front-end arithmetic
  logic signed [SUM_W-1:0]  sum_r  [N_AX];
  logic [SUM_W-1:0]         smag_r [N_AX];
  logic                     sneg_r [N_AX];
  logic signed [DIFF_W-1:0] secd_r;
  logic signed [NSD_W-1:0]  nsd_r;
  logic signed [DT_W-1:0]   dtsec_r, dt_r;
  logic [DMAG_W-1:0]        dmag_r;
  logic                     dneg_r, dtz_r;

  // Products
  logic [P_W-1:0]           p_r;
  logic [PK_W-1:0]          pkv_r, pky_r;
  logic [DV_W-1:0]          dv_r;
  logic [DY_W-1:0]          dy_r;

  // Shift-add multiplier / restoring divider
  logic [DP_W-1:0]          acc_r, mca_r;
  logic [MB_W-1:0]          mcb_r;
  logic [Q_W-1:0]           q_r;

  // Results
  logic signed [VEL_W-1:0]  vel_r [N_AX];
  logic                     sat_r;
  logic signed [VEL_W-1:0]  vx_r, vy_r, yaw_r;
  logic [SEC_W-1:0]         osec_r;
  logic [NSEC_W-1:0]        onsec_r;
  logic [mwo_pkg::STAT_W-1:0] status_r;

  logic signed [DIFF_W-1:0] d [4];
  logic signed [SUM_W-1:0]  s_nxt [N_AX];
  logic signed [DT_W-1:0]   secd_ext, ns_const;
  logic [mwo_pkg::TPR_W-1:0]  n1;
  logic [mwo_pkg::GEAR_W-1:0] g1;
  logic [mwo_pkg::HTS_W-1:0]  l1;
  logic [DP_W-1:0]          load_a;
  logic [MB_W-1:0]          load_b;
  logic [DP_W-1:0]          dbase;
  logic                     sub;
  logic [DP_W-1:0]          add_a, add_b;
  logic [DP_W:0]            sum_w;
  logic                     rneg, rsat;
  logic [VEL_W-1:0]         qlo;
  logic signed [VEL_W-1:0]  vres;

  // Wheel deltas and mecanum combinations
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      d[i] = DIFF_W'(cur_tick_r[i]) - DIFF_W'(prev_tick_r[i]);
    end
    s_nxt[0] =  SUM_W'(d[0]) + SUM_W'(d[1]) + SUM_W'(d[2]) + SUM_W'(d[3]);
    s_nxt[1] = -SUM_W'(d[0]) + SUM_W'(d[1]) + SUM_W'(d[2]) - SUM_W'(d[3]);
    s_nxt[2] = -SUM_W'(d[0]) + SUM_W'(d[1]) - SUM_W'(d[2]) + SUM_W'(d[3]);
  end

  assign secd_ext = DT_W'(secd_r);
  assign ns_const = DT_W'($signed({1'b0, mwo_pkg::NS_PER_SEC}));

  // Zero divisor registers count as one
  assign n1 = (ticks_per_rev == '0) ? mwo_pkg::TPR_W'(1) : ticks_per_rev;
  assign g1 = (gear_ratio == '0) ? mwo_pkg::GEAR_W'(1) : gear_ratio;
  assign l1 = (half_track_sum_um == '0) ? mwo_pkg::HTS_W'(1) : half_track_sum_um;

  // Multiplier operands per product
  always_comb begin
    case (cmd.job)
      mwo_pkg::JOB_P: begin
        load_a = DP_W'(mwo_pkg::PI_Q29);
        load_b = MB_W'(wheel_radius_um);
      end
      mwo_pkg::JOB_PKV: begin
        load_a = DP_W'(p_r);
        load_b = MB_W'(mwo_pkg::K_LIN);
      end
      mwo_pkg::JOB_PKY: begin
        load_a = DP_W'(p_r);
        load_b = MB_W'(mwo_pkg::K_YAW);
      end
      mwo_pkg::JOB_DN: begin
        load_a = DP_W'(dmag_r);
        load_b = MB_W'(n1);
      end
      mwo_pkg::JOB_DG: begin
        load_a = DP_W'(dv_r);
        load_b = MB_W'(g1);
      end
      mwo_pkg::JOB_DL: begin
        load_a = DP_W'(dv_r);
        load_b = MB_W'(l1);
      end
      mwo_pkg::JOB_NUM: begin
        load_a = (cmd.axis == mwo_pkg::AXIS_YAW) ? DP_W'(pky_r) : DP_W'(pkv_r);
        load_b = MB_W'(smag_r[cmd.axis]);
      end
      default: begin
        load_a = '0;
        load_b = '0;
      end
    endcase
  end

  // Denominator of the current axis
  assign dbase = (cmd.axis == mwo_pkg::AXIS_YAW) ? DP_W'(dy_r) : DP_W'(dv_r);

  // Single wide adder: accumulate, form dividend, trial subtract
  assign sub   = (cmd.op == mwo_pkg::OP_DIV_STEP);
  assign add_a = (cmd.op == mwo_pkg::OP_X_ADD) ? (acc_r << 1) : acc_r;
  assign add_b = sub ? ~mca_r : mca_r;
  assign sum_w = {1'b0, add_a} + {1'b0, add_b} + (DP_W + 1)'(sub);

  // Sign, saturation and negation of one quotient
  always_comb begin
    rneg = sneg_r[cmd.axis] ^ dneg_r;
    qlo  = q_r[VEL_W-1:0];
    if (rneg) begin
      rsat = q_r[Q_W-1] | (q_r[VEL_W-1] & (|q_r[VEL_W-2:0]));
    end else begin
      rsat = q_r[Q_W-1] | q_r[VEL_W-1];
    end
    if (rsat) begin
      vres = rneg ? VEL_MIN : VEL_MAX;
    end else begin
      vres = rneg ? $signed(VEL_W'(0) - qlo) : $signed(qlo);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      mwo_pkg::OP_CAPTURE: begin
        cur_tick_r[0] <= tick_front_left;
        cur_tick_r[1] <= tick_front_right;
        cur_tick_r[2] <= tick_rear_right;
        cur_tick_r[3] <= tick_rear_left;
        cur_sec_r     <= stamp_sec;
        cur_nsec_r    <= stamp_nsec;
      end
      mwo_pkg::OP_DIFF: begin
        for (int i = 0; i < N_AX; i++) begin
          sum_r[i] <= s_nxt[i];
        end
        secd_r <= $signed({1'b0, cur_sec_r}) - $signed({1'b0, prev_sec_r});
        nsd_r  <= $signed({1'b0, cur_nsec_r}) - $signed({1'b0, prev_nsec_r});
      end
      mwo_pkg::OP_DTMUL: begin
        dtsec_r <= secd_ext * ns_const;
      end
      mwo_pkg::OP_DTADD: begin
        dt_r <= dtsec_r + DT_W'(nsd_r);
      end
      mwo_pkg::OP_MAG: begin
        dneg_r <= dt_r[DT_W-1];
        dmag_r <= DMAG_W'(dt_r[DT_W-1] ? -dt_r : dt_r);
        dtz_r  <= (dt_r == '0);
        sat_r  <= 1'b0;
        for (int i = 0; i < N_AX; i++) begin
          sneg_r[i] <= sum_r[i][SUM_W-1];
          smag_r[i] <= sum_r[i][SUM_W-1] ? SUM_W'(-sum_r[i]) : SUM_W'(sum_r[i]);
        end
      end
      mwo_pkg::OP_MUL_LOAD: begin
        acc_r <= '0;
        mca_r <= load_a;
        mcb_r <= load_b;
      end
      mwo_pkg::OP_MUL_STEP: begin
        if (mcb_r[0]) begin
          acc_r <= sum_w[DP_W-1:0];
        end
        mca_r <= mca_r << 1;
        mcb_r <= mcb_r >> 1;
      end
      mwo_pkg::OP_MUL_STORE: begin
        case (cmd.job)
          mwo_pkg::JOB_P:   p_r   <= acc_r[P_W-1:0];
          mwo_pkg::JOB_PKV: pkv_r <= acc_r[PK_W-1:0];
          mwo_pkg::JOB_PKY: pky_r <= acc_r[PK_W-1:0];
          mwo_pkg::JOB_DN:  dv_r  <= acc_r[DV_W-1:0];
          mwo_pkg::JOB_DG:  dv_r  <= acc_r[DV_W-1:0];
          mwo_pkg::JOB_DL:  dy_r  <= acc_r[DY_W-1:0];
          default: ;
        endcase
      end
      mwo_pkg::OP_X_LOAD: begin
        // half the doubled divisor, added for round half away from zero
        mca_r <= dbase << SH_X;
      end
      mwo_pkg::OP_X_ADD: begin
        acc_r <= sum_w[DP_W-1:0];
      end
      mwo_pkg::OP_DIV_LOAD: begin
        mca_r <= dbase << SH_D;
        q_r   <= '0;
      end
      mwo_pkg::OP_DIV_STEP: begin
        if (sum_w[DP_W]) begin
          acc_r <= sum_w[DP_W-1:0];
        end
        q_r   <= {q_r[Q_W-2:0], sum_w[DP_W]};
        mca_r <= mca_r >> 1;
      end
      mwo_pkg::OP_RESULT: begin
        vel_r[cmd.axis] <= vres;
        sat_r           <= sat_r | rsat;
      end
      mwo_pkg::OP_EMIT: begin
        if (cmd.code == mwo_pkg::STAT_CALC) begin
          vx_r     <= vel_r[0];
          vy_r     <= vel_r[1];
          yaw_r    <= vel_r[2];
          status_r <= sat_r ? mwo_pkg::STAT_SAT : mwo_pkg::STAT_CALC;
        end else begin
          vx_r     <= '0;
          vy_r     <= '0;
          yaw_r    <= '0;
          status_r <= cmd.code;
        end
        osec_r  <= cur_sec_r;
        onsec_r <= cur_nsec_r;
        // current sample becomes the reference
        for (int i = 0; i < 4; i++) begin
          prev_tick_r[i] <= cur_tick_r[i];
        end
        prev_sec_r  <= cur_sec_r;
        prev_nsec_r <= cur_nsec_r;
      end
      default: ;
    endcase
  end

  assign stat.mul_done = (mcb_r == '0);
  assign stat.dt_zero  = dtz_r;

  assign vel_x    = vx_r;
  assign vel_y    = vy_r;
  assign yaw_rate = yaw_r;
  assign res_sec  = osec_r;
  assign res_nsec = onsec_r;
  assign status   = status_r;

endmodule

@@ rtl/mecanum_wheel_odometry.sv @@
`timescale 1ns / 1ps
// Channel  Handshake              Payload
// in       in_valid / in_ready    in_tick_* (4 x s32), in_stamp_sec, in_stamp_nsec
// out      out_valid / out_ready  out_vel_x, out_vel_y, out_yaw_rate, out_sec,
//                                 out_nsec, out_status
// cfg      cfg_we                 cfg_index, cfg_wdata (write only, no wait)
//
// A skipped sample is only captured; the first sample and a zero interval emit with no products.
// A computed sample runs six setup products and three numerators through one
// shift-add multiplier (one multiplier bit per cycle, each product ending when its
// multiplier operand has no set bits left) and three 33-step restoring divisions,
// all on one shared wide adder.
// Synchronous active-low reset restores the configuration and control registers and drops the reference.
// A result held in the output register stalls only the next emitted result.

module mecanum_wheel_odometry #(
  parameter int FRAC_BITS = mwo_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [mwo_pkg::TICK_W-1:0]      in_tick_front_left,
  input  logic signed [mwo_pkg::TICK_W-1:0]      in_tick_front_right,
  input  logic signed [mwo_pkg::TICK_W-1:0]      in_tick_rear_right,
  input  logic signed [mwo_pkg::TICK_W-1:0]      in_tick_rear_left,
  input  logic [mwo_pkg::SEC_W-1:0]              in_stamp_sec,
  input  logic [mwo_pkg::NSEC_W-1:0]             in_stamp_nsec,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [mwo_pkg::VEL_W-1:0]       out_vel_x,
  output logic signed [mwo_pkg::VEL_W-1:0]       out_vel_y,
  output logic signed [mwo_pkg::VEL_W-1:0]       out_yaw_rate,
  output logic [mwo_pkg::SEC_W-1:0]              out_sec,
  output logic [mwo_pkg::NSEC_W-1:0]             out_nsec,
  output logic [mwo_pkg::STAT_W-1:0]             out_status,
  input  logic                                   cfg_we,
  input  logic [mwo_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [mwo_pkg::CFG_DATA_W-1:0]         cfg_wdata
);

  logic [mwo_pkg::TPR_W-1:0]  tpr_r;
  logic [mwo_pkg::GEAR_W-1:0] gear_r;
  logic [mwo_pkg::RAD_W-1:0]  rad_r;
  logic [mwo_pkg::HTS_W-1:0]  hts_r;
  logic [mwo_pkg::SKIP_W-1:0] skip_r;

  mwo_pkg::dp_cmd_t  cmd;
  mwo_pkg::dp_stat_t stat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpr_r  <= mwo_pkg::TPR_RST;
      gear_r <= mwo_pkg::GEAR_RST;
      rad_r  <= mwo_pkg::RAD_RST;
      hts_r  <= mwo_pkg::HTS_RST;
      skip_r <= mwo_pkg::SKIP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mwo_pkg::REG_TPR:  tpr_r  <= cfg_wdata[mwo_pkg::TPR_W-1:0];
        mwo_pkg::REG_GEAR: gear_r <= cfg_wdata[mwo_pkg::GEAR_W-1:0];
        mwo_pkg::REG_RAD:  rad_r  <= cfg_wdata[mwo_pkg::RAD_W-1:0];
        mwo_pkg::REG_HTS:  hts_r  <= cfg_wdata[mwo_pkg::HTS_W-1:0];
        mwo_pkg::REG_SKIP: skip_r <= cfg_wdata[mwo_pkg::SKIP_W-1:0];
        default: ;
      endcase
    end
  end

  mwo_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .skip_count (skip_r),
    .cmd        (cmd),
    .stat       (stat)
  );

  mwo_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk               (clk),
    .ticks_per_rev     (tpr_r),
    .gear_ratio        (gear_r),
    .wheel_radius_um   (rad_r),
    .half_track_sum_um (hts_r),
    .tick_front_left   (in_tick_front_left),
    .tick_front_right  (in_tick_front_right),
    .tick_rear_right   (in_tick_rear_right),
    .tick_rear_left    (in_tick_rear_left),
    .stamp_sec         (in_stamp_sec),
    .stamp_nsec        (in_stamp_nsec),
    .cmd               (cmd),
    .stat              (stat),
    .vel_x             (out_vel_x),
    .vel_y             (out_vel_y),
    .yaw_rate          (out_yaw_rate),
    .res_sec           (out_sec),
    .res_nsec          (out_nsec),
    .status            (out_status)
  );

endmodule
